@@ rtl/lte_pkg.sv @@
// Shared types and constants for the line table program encoder.
// Used by lte_front, lte_cmd_q, lte_back and line_table_program_encoder.
package lte_pkg;

	localparam logic [1:0] ACT_ENTRY = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	localparam logic [7:0] OP_EXT        = 8'h00;
	localparam logic [7:0] OP_COPY       = 8'h01;
	localparam logic [7:0] OP_ADV_PC     = 8'h02;
	localparam logic [7:0] OP_ADV_LINE   = 8'h03;
	localparam logic [7:0] EXT_LEN_ADDR  = 8'h09;
	localparam logic [7:0] EXT_SET_ADDR  = 8'h02;
	localparam logic [7:0] EXT_LEN_END   = 8'h01;
	localparam logic [7:0] EXT_END_SEQ   = 8'h01;

	localparam logic [3:0] START_LAST_IDX = 4'd10;
	localparam logic [3:0] END_LAST_IDX   = 4'd2;

	localparam int CMD_QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] off_step;
		logic [31:0] row_step;
	} cmd_t;

endpackage

@@ rtl/lte_front.sv @@
// Front end: accepts input words, tracks running offset and line, forms deltas.
// Depends on lte_pkg.
module lte_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [1:0]        action,
	input  logic [30:0]       src_line,
	input  logic [31:0]       code_off,
	output logic              push,
	output lte_pkg::cmd_t     cmd
);

	logic [31:0] run_off_q;
	logic [30:0] run_line_q;

	assign push         = in_fire && (action != lte_pkg::ACT_NONE);
	assign cmd.kind     = action;
	assign cmd.off_step = code_off - run_off_q;
	assign cmd.row_step = {1'b0, src_line} - {1'b0, run_line_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_off_q  <= '0;
			run_line_q <= 31'd1;
		end else if (in_fire) begin
			if (action == lte_pkg::ACT_START) begin
				run_off_q  <= '0;
				run_line_q <= 31'd1;
			end else if (action == lte_pkg::ACT_ENTRY) begin
				run_off_q  <= code_off;
				run_line_q <= src_line;
			end
		end
	end

endmodule

@@ rtl/lte_cmd_q.sv @@
// Small command queue between front and back end.
// Depends on lte_pkg.
module lte_cmd_q #(
	parameter int DEPTH = lte_pkg::CMD_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lte_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output lte_pkg::cmd_t rd_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	lte_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;

	assign full      = (count_q == (AW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop && not_empty)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if ((push && !full) && !(pop && not_empty))
				count_q <= count_q + 1'b1;
			else if (!(push && !full) && (pop && not_empty))
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/lte_back.sv @@
// Back end: turns one command into program bytes, one per cycle unless m_tready stalls, with LEB128 steps.
// Depends on lte_pkg.
module lte_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  lte_pkg::cmd_t cmd,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_START  = 3'd1;
	localparam logic [2:0] ST_END    = 3'd2;
	localparam logic [2:0] ST_PC_OP  = 3'd3;
	localparam logic [2:0] ST_PC_LEB = 3'd4;
	localparam logic [2:0] ST_LN_OP  = 3'd5;
	localparam logic [2:0] ST_LN_LEB = 3'd6;
	localparam logic [2:0] ST_COPY   = 3'd7;

	logic [2:0]  state_q, state_d;
	logic [3:0]  cnt_q;
	logic [31:0] pc_q;
	logic [31:0] ln_q;
	logic        ln_nz_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        gen_valid, gen_last, fire, pc_done, ln_done;
	logic [7:0]  gen_byte;
	logic [31:0] ln_shift;

	assign pc_done  = (pc_q[31:7] == '0);
	assign ln_shift = $signed(ln_q) >>> 7;
	assign ln_done  = ((ln_shift == '0) && !ln_q[6]) || ((ln_shift == '1) && ln_q[6]);

	assign pop = (state_q == ST_IDLE) && cmd_valid;

	always_comb begin
		gen_valid = 1'b1;
		gen_last  = 1'b0;
		gen_byte  = lte_pkg::OP_EXT;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				gen_valid = 1'b0;
			end
			ST_START: begin
				if (cnt_q == 4'd1)
					gen_byte = lte_pkg::EXT_LEN_ADDR;
				else if (cnt_q == 4'd2)
					gen_byte = lte_pkg::EXT_SET_ADDR;
				gen_last = (cnt_q == lte_pkg::START_LAST_IDX);
				if (gen_last)
					state_d = ST_IDLE;
			end
			ST_END: begin
				if (cnt_q == 4'd1)
					gen_byte = lte_pkg::EXT_LEN_END;
				else if (cnt_q == 4'd2)
					gen_byte = lte_pkg::EXT_END_SEQ;
				gen_last = (cnt_q == lte_pkg::END_LAST_IDX);
				if (gen_last)
					state_d = ST_IDLE;
			end
			ST_PC_OP: begin
				gen_byte = lte_pkg::OP_ADV_PC;
				state_d  = ST_PC_LEB;
			end
			ST_PC_LEB: begin
				gen_byte = {!pc_done, pc_q[6:0]};
				if (pc_done)
					state_d = ln_nz_q ? ST_LN_OP : ST_COPY;
			end
			ST_LN_OP: begin
				gen_byte = lte_pkg::OP_ADV_LINE;
				state_d  = ST_LN_LEB;
			end
			ST_LN_LEB: begin
				gen_byte = {!ln_done, ln_q[6:0]};
				if (ln_done)
					state_d = ST_COPY;
			end
			ST_COPY: begin
				gen_byte = lte_pkg::OP_COPY;
				gen_last = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				gen_valid = 1'b0;
			end
		endcase
	end

	assign fire = gen_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cnt_q <= '0;
				unique case (cmd.kind)
					lte_pkg::ACT_START: state_q <= ST_START;
					lte_pkg::ACT_END:   state_q <= ST_END;
					default: begin
						if (cmd.off_step != '0)
							state_q <= ST_PC_OP;
						else if (cmd.row_step != '0)
							state_q <= ST_LN_OP;
						else
							state_q <= ST_COPY;
					end
				endcase
			end else if (fire) begin
				state_q <= state_d;
				cnt_q   <= cnt_q + 1'b1;
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pc_q    <= cmd.off_step;
			ln_q    <= cmd.row_step;
			ln_nz_q <= (cmd.row_step != '0);
		end else if (fire) begin
			if (state_q == ST_PC_LEB)
				pc_q <= pc_q >> 7;
			if (state_q == ST_LN_LEB)
				ln_q <= ln_shift;
		end
		if (fire) begin
			out_byte_q <= gen_byte;
			out_last_q <= gen_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/line_table_program_encoder.sv @@
// Line table program encoder: an item enters on the slave side, its command waits in a
// short queue, and the back end sends its bytes one per cycle on the master side while
// m_tready allows. The back end loads a command while idle and sends its bytes before
// it takes the next: 1 to 13 bytes for an entry, 11 for a start, 3 for an end. Action 3
// is taken and dropped. The input side stalls only while the command queue is full.
// Depends on lte_pkg, lte_front, lte_cmd_q and lte_back.
module line_table_program_encoder #(
	parameter int QUEUE_DEPTH = lte_pkg::CMD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [30:0] source line, [62:31] code offset, [63] zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast
);

	logic          in_fire, push, q_full, q_valid, pop;
	lte_pkg::cmd_t wr_cmd, rd_cmd;

	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	lte_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.action   (s_tuser),
		.src_line (s_tdata[30:0]),
		.code_off (s_tdata[62:31]),
		.push     (push),
		.cmd      (wr_cmd)
	);

	lte_cmd_q #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.rd_cmd    (rd_cmd)
	);

	lte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (rd_cmd),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

@@ tb/line_table_program_encoder_tb.sv @@
// Testbench for line_table_program_encoder: directed and random line programs, with a
// local byte-level predictor, idling and stalls on both stream sides, and a long hold-off.
// Depends on lte_pkg and the encoder RTL.
`timescale 1ns / 100ps

module line_table_program_encoder_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 24;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} prog_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	prog_byte_t  program_bytes[$];
	prog_byte_t  head_byte;
	logic [31:0] cur_offset = '0;
	logic [30:0] run_row = 31'd1;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_cnt = 0;
	int          err_cnt = 0;
	int          cycle_cnt = 0;
	logic [31:0] gen_pc;
	logic [30:0] gen_line;

	line_table_program_encoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void push_byte(input logic [7:0] b);
		program_bytes.push_back('{data: b, last: 1'b0});
	endfunction

	function automatic void push_uleb(input logic [31:0] v);
		logic [7:0] b;
		bit         more;
		more = 1'b1;
		while (more) begin
			b = {1'b0, v[6:0]};
			v = v >> 7;
			more = (v != 0);
			if (more) b[7] = 1'b1;
			push_byte(b);
		end
	endfunction

	function automatic void push_sleb(input longint v);
		logic [7:0] b;
		bit         more;
		more = 1'b1;
		while (more) begin
			b = {1'b0, v[6:0]};
			v = v >>> 7;
			if ((v == 0 && !b[6]) || (v == -1 && b[6])) more = 1'b0;
			else b[7] = 1'b1;
			push_byte(b);
		end
	endfunction

	// Expected program bytes for one accepted word; updates the running offset and row.
	function automatic void encode_word(input logic [1:0] act, input logic [30:0] ln,
			input logic [31:0] pc);
		int          n0;
		logic [31:0] off_step;
		longint      row_step;
		n0 = program_bytes.size();
		case (act)
			lte_pkg::ACT_START: begin
				cur_offset = '0;
				run_row = 31'd1;
				push_byte(lte_pkg::OP_EXT);
				push_uleb(32'(lte_pkg::EXT_LEN_ADDR));
				push_byte(lte_pkg::EXT_SET_ADDR);
				repeat (8) push_byte(8'h00);
			end
			lte_pkg::ACT_ENTRY: begin
				off_step = pc - cur_offset;
				row_step = longint'(ln) - longint'(run_row);
				if (off_step != 0) begin
					push_byte(lte_pkg::OP_ADV_PC);
					push_uleb(off_step);
					cur_offset = pc;
				end
				if (row_step != 0) begin
					push_byte(lte_pkg::OP_ADV_LINE);
					push_sleb(row_step);
					run_row = ln;
				end
				push_byte(lte_pkg::OP_COPY);
			end
			lte_pkg::ACT_END: begin
				push_byte(lte_pkg::OP_EXT);
				push_uleb(32'(lte_pkg::EXT_LEN_END));
				push_byte(lte_pkg::EXT_END_SEQ);
			end
			default: ;
		endcase
		if (program_bytes.size() > n0) program_bytes[$].last = 1'b1;
	endfunction

	// Called at a falling edge; returns at a falling edge with s_tvalid still high.
	task automatic send_word(input logic [1:0] act, input logic [30:0] ln,
			input logic [31:0] pc);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, pc, ln};
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		encode_word(act, ln, pc);
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (program_bytes.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_pc_step();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15) return 32'd0;
		if (pick < 55) return $urandom_range(127, 1);
		if (pick < 75) return $urandom_range(16383, 128);
		return $urandom();
	endfunction

	function automatic logic [30:0] rand_line_step();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20) return 31'd0;
		if (pick < 50) return 31'($urandom_range(70, 1));
		if (pick < 75) return -31'($urandom_range(70, 1));
		if (pick < 88) return 31'($urandom_range(20000) - 10000);
		return 31'($urandom());
	endfunction

	// Well-formed sequences with random content, sprinkled with noise and broken ones.
	task automatic send_program(input int n);
		int sent;
		int rows;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) != 0) begin
				send_word(lte_pkg::ACT_START, 31'($urandom()), $urandom());
				sent++;
				gen_pc = '0;
				gen_line = 31'd1;
			end
			rows = $urandom_range(10, 1);
			repeat (rows) begin
				if ($urandom_range(99) < 8) begin
					send_word(lte_pkg::ACT_NONE, 31'($urandom()), $urandom());
				end else if ($urandom_range(99) < 5) begin
					gen_pc = $urandom();
					gen_line = 31'($urandom());
					send_word(lte_pkg::ACT_ENTRY, gen_line, gen_pc);
					sent++;
				end else begin
					gen_pc = gen_pc + rand_pc_step();
					gen_line = gen_line + rand_line_step();
					send_word(lte_pkg::ACT_ENTRY, gen_line, gen_pc);
					sent++;
				end
			end
			if ($urandom_range(9) != 0) begin
				send_word(lte_pkg::ACT_END, 31'($urandom()), $urandom());
				sent++;
			end
		end
	endtask

	task automatic test_directed;
		idle_pct = 0;
		stall_pct = 0;
		send_word(lte_pkg::ACT_ENTRY, 31'd1, 32'd0);
		send_word(lte_pkg::ACT_ENTRY, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_word(lte_pkg::ACT_ENTRY, 31'd0, 32'd0);
		send_word(lte_pkg::ACT_NONE, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_word(lte_pkg::ACT_START, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_word(lte_pkg::ACT_ENTRY, 31'd1, 32'd0);
		send_word(lte_pkg::ACT_ENTRY, 31'd64, 32'd127);
		send_word(lte_pkg::ACT_ENTRY, 31'd128, 32'd255);
		send_word(lte_pkg::ACT_ENTRY, 31'd64, 32'd255);
		send_word(lte_pkg::ACT_ENTRY, 31'd128, 32'd256);
		send_word(lte_pkg::ACT_ENTRY, 31'd63, 32'd16);
		send_word(lte_pkg::ACT_END, 31'd0, 32'd0);
		send_word(lte_pkg::ACT_END, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_word(lte_pkg::ACT_ENTRY, 31'h2AAA_AAAA, 32'h5555_5555);
		send_word(lte_pkg::ACT_ENTRY, 31'h5555_5555, 32'hAAAA_AAAA);
		send_word(lte_pkg::ACT_ENTRY, 31'h5555_5555, 32'hAAAA_AAAA);
		send_word(lte_pkg::ACT_START, 31'd0, 32'd0);
		send_word(lte_pkg::ACT_ENTRY, 31'd0, 32'd1);
		send_word(lte_pkg::ACT_END, 31'd0, 32'd0);
		drain();
	endtask

	task automatic test_random(input int n, input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
		send_program(n);
		drain();
	endtask

	task automatic test_backpressure;
		idle_pct = 0;
		stall_pct = 0;
		hold_cnt = 400;
		send_program(25);
		drain();
		stall_pct = 20;
		send_program(15);
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (program_bytes.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected word: byte %h last %b", m_tdata, m_tlast);
			end else begin
				head_byte = program_bytes.pop_front();
				if (m_tdata !== head_byte.data || m_tlast !== head_byte.last) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: expected byte %h last %b, got byte %h last %b",
							head_byte.data, head_byte.last, m_tdata, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(60, 0, 0);
		test_random(85, 58, 0);
		test_random(85, 0, 58);
		test_random(85, 36, 36);
		test_backpressure();
		if (err_cnt == 0 && program_bytes.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/lte_pkg.sv
rtl/lte_front.sv
rtl/lte_cmd_q.sv
rtl/lte_back.sv
rtl/line_table_program_encoder.sv
tb/line_table_program_encoder_tb.sv
